/* hdl/yaw_box_pair_overlap_test_macros.svh */
// Assertion macros for the yaw box pair overlap test
`ifndef YAW_BOX_PAIR_OVERLAP_TEST_MACROS_SVH
`define YAW_BOX_PAIR_OVERLAP_TEST_MACROS_SVH
`ifndef SYNTH
`define YBPO_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define YBPO_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define YBPO_ASSERT_SAME(name, ante, cons)
`define YBPO_ASSERT_NEXT(name, ante, cons)
`endif
`endif

/* hdl/ybpo_pkg.sv */
// Shared constants, tables and types of the yaw box pair overlap test
package ybpo_pkg;

    localparam int COORD_BITS   = 32;
    localparam int SIZE_BITS    = COORD_BITS - 1;
    localparam int ANGLE_BITS   = 16;
    localparam int TOL_BITS     = 16;
    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_FRAC  = 30;
    localparam int TRIG_FRAC    = (COORD_BITS + 30 > 61) ? 61 - COORD_BITS : 30;
    localparam int TRIG_SHIFT   = CORDIC_FRAC - TRIG_FRAC;
    localparam int XY_BITS      = CORDIC_FRAC + 3;
    localparam int Z_BITS       = 32;
    localparam int TRIG_BITS    = TRIG_FRAC + 2;
    localparam int MAG_BITS     = TRIG_FRAC + 1;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 2;

    localparam logic signed [XY_BITS-1:0] CORDIC_GAIN = XY_BITS'(652032874);
    localparam logic signed [XY_BITS-1:0] CORDIC_ONE  = XY_BITS'(64'd1 << CORDIC_FRAC);

    localparam logic [Z_BITS-1:0] ATAN_TURN [0:CORDIC_STEPS-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
        32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
        32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
        32'd20, 32'd10, 32'd5, 32'd3, 32'd1
    };

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef struct packed {
        logic signed [TRIG_BITS-1:0] cos_s;
        logic signed [TRIG_BITS-1:0] sin_s;
        logic        [MAG_BITS-1:0]  cos_m;
        logic        [MAG_BITS-1:0]  sin_m;
    } trig_t;

endpackage

/* hdl/yaw_box_pair_overlap_test.sv */
// Top level of the yaw box pair overlap test
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------------
//  in       | in_valid / in_stall    | delta_x..z, size_a_*, yaw_a, size_b_*, yaw_b
//  out      | out_valid / out_stall  | collides
//  cfg      | cfg_valid / cfg_ready  | cfg_data (contact_tolerance)
//
// One item enters per cycle while in_stall is low. Each item passes the 30-step
// CORDIC pipeline with its entry and rounding stages, then the multiply, add
// and compare stages.
// rst_n clears the valid bits and the tolerance register asynchronously.
// While the output holds an untaken result under out_stall, the whole
// pipeline holds and in_stall is raised.
`include "yaw_box_pair_overlap_test_macros.svh"

module yaw_box_pair_overlap_test
    import ybpo_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] delta_x,
    input  logic signed [COORD_BITS-1:0] delta_y,
    input  logic signed [COORD_BITS-1:0] delta_z,
    input  logic        [SIZE_BITS-1:0]  size_a_x,
    input  logic        [SIZE_BITS-1:0]  size_a_y,
    input  logic        [SIZE_BITS-1:0]  size_a_z,
    input  logic        [ANGLE_BITS-1:0] yaw_a,
    input  logic        [SIZE_BITS-1:0]  size_b_x,
    input  logic        [SIZE_BITS-1:0]  size_b_y,
    input  logic        [SIZE_BITS-1:0]  size_b_z,
    input  logic        [ANGLE_BITS-1:0] yaw_b,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         collides,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic        [TOL_BITS-1:0]   cfg_data
);

    localparam int DLY    = CORDIC_LAT;
    localparam int PROD_W = COORD_BITS + TRIG_BITS;
    localparam int RAD_W  = SIZE_BITS + MAG_BITS;
    localparam int SUM_W  = 64;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] dx;
        logic signed [COORD_BITS-1:0] dz;
        logic        [SIZE_BITS-1:0]  ax;
        logic        [SIZE_BITS-1:0]  az;
        logic        [SIZE_BITS-1:0]  bx;
        logic        [SIZE_BITS-1:0]  bz;
        logic                         vgap;
    } item_t;

    logic                en;
    logic [TOL_BITS-1:0] tol_reg;
    logic [DLY-1:0]      v_reg;
    item_t               pipe_reg [0:DLY-1];
    item_t               entry;

    logic [COORD_BITS:0]   dy_mag;
    logic [COORD_BITS+1:0] dy_twice;
    logic [COORD_BITS+1:0] h_sum;
    logic [ANGLE_BITS-1:0] yaw_d;

    trig_t ta;
    trig_t tb;
    trig_t td;

    logic signed [PROD_W-1:0] mp_next [0:7];
    logic signed [PROD_W-1:0] mp_reg  [0:7];
    logic        [RAD_W-1:0]  mr_next [0:7];
    logic        [RAD_W-1:0]  mr_reg  [0:7];
    logic        [SUM_W-1:0]  k_next  [0:3];
    logic        [SUM_W-1:0]  k_reg   [0:3];
    logic        [SUM_W-1:0]  k2_reg  [0:3];
    logic        [SIZE_BITS-1:0] own  [0:3];
    logic                     pv_reg;
    logic                     pgap_reg;

    logic signed [PROD_W-1:0] p_next  [0:3];
    logic signed [PROD_W-1:0] p_reg   [0:3];
    logic        [RAD_W:0]    rp_next [0:3];
    logic        [RAD_W:0]    rp_reg  [0:3];
    logic                     sv_reg;
    logic                     sgap_reg;

    logic [PROD_W-1:0] p_abs;
    logic [SUM_W-1:0]  lhs;
    logic [SUM_W-1:0]  rhs;
    logic [3:0]        axis_ok;
    logic              out_valid_reg;
    logic              collides_reg;
    logic              collides_next;

    assign en        = !(out_valid_reg && out_stall);
    assign in_stall  = !en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= '0;
        else if (cfg_valid && cfg_ready)
            tol_reg <= cfg_data;
    end

    // vertical gap test on entry
    always_comb
    begin
        dy_mag   = delta_y[COORD_BITS-1] ? (COORD_BITS+1)'(-$signed({1'b1, delta_y}))
                                         : {1'b0, delta_y};
        dy_twice = {dy_mag, 1'b0};
        h_sum    = (COORD_BITS+2)'(size_a_y) + (COORD_BITS+2)'(size_b_y);
        entry.dx   = delta_x;
        entry.dz   = delta_z;
        entry.ax   = size_a_x;
        entry.az   = size_a_z;
        entry.bx   = size_b_x;
        entry.bz   = size_b_z;
        entry.vgap = (dy_twice >= h_sum);
    end

    assign yaw_d = yaw_b - yaw_a;

    ybpo_cordic u_cordic_a (.clk(clk), .en(en), .angle(yaw_a), .trig(ta));
    ybpo_cordic u_cordic_b (.clk(clk), .en(en), .angle(yaw_b), .trig(tb));
    ybpo_cordic u_cordic_d (.clk(clk), .en(en), .angle(yaw_d), .trig(td));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            pv_reg        <= 1'b0;
            sv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg         <= {v_reg[DLY-2:0], in_valid};
            pv_reg        <= v_reg[DLY-1];
            sv_reg        <= pv_reg;
            out_valid_reg <= sv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pipe_reg[0] <= entry;
            for (int i = 1; i < DLY; i++)
                pipe_reg[i] <= pipe_reg[i-1];
        end
    end

    // products of the four axis projections and radii
    always_comb
    begin
        item_t it;
        it = pipe_reg[DLY-1];
        mp_next[0] = PROD_W'(it.dx) * PROD_W'(ta.cos_s);
        mp_next[1] = PROD_W'(it.dz) * PROD_W'(ta.sin_s);
        mp_next[2] = PROD_W'(it.dz) * PROD_W'(ta.cos_s);
        mp_next[3] = PROD_W'(it.dx) * PROD_W'(ta.sin_s);
        mp_next[4] = PROD_W'(it.dx) * PROD_W'(tb.cos_s);
        mp_next[5] = PROD_W'(it.dz) * PROD_W'(tb.sin_s);
        mp_next[6] = PROD_W'(it.dz) * PROD_W'(tb.cos_s);
        mp_next[7] = PROD_W'(it.dx) * PROD_W'(tb.sin_s);
        mr_next[0] = RAD_W'(it.bx) * RAD_W'(td.cos_m);
        mr_next[1] = RAD_W'(it.bz) * RAD_W'(td.sin_m);
        mr_next[2] = RAD_W'(it.bx) * RAD_W'(td.sin_m);
        mr_next[3] = RAD_W'(it.bz) * RAD_W'(td.cos_m);
        mr_next[4] = RAD_W'(it.ax) * RAD_W'(td.cos_m);
        mr_next[5] = RAD_W'(it.az) * RAD_W'(td.sin_m);
        mr_next[6] = RAD_W'(it.ax) * RAD_W'(td.sin_m);
        mr_next[7] = RAD_W'(it.az) * RAD_W'(td.cos_m);
        own[0] = it.ax;
        own[1] = it.az;
        own[2] = it.bx;
        own[3] = it.bz;
        for (int j = 0; j < 4; j++)
            k_next[j] = (SUM_W'(own[j]) << TRIG_FRAC) + (SUM_W'(tol_reg) << (TRIG_FRAC + 1));
    end

    always_comb
    begin
        p_next[0] = mp_reg[0] + mp_reg[1];
        p_next[1] = mp_reg[2] - mp_reg[3];
        p_next[2] = mp_reg[4] + mp_reg[5];
        p_next[3] = mp_reg[6] - mp_reg[7];
        for (int j = 0; j < 4; j++)
            rp_next[j] = (RAD_W+1)'(mr_reg[2*j]) + (RAD_W+1)'(mr_reg[2*j+1]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mp_reg   <= mp_next;
            mr_reg   <= mr_next;
            k_reg    <= k_next;
            pgap_reg <= pipe_reg[DLY-1].vgap;
            p_reg    <= p_next;
            rp_reg   <= rp_next;
            k2_reg   <= k_reg;
            sgap_reg <= pgap_reg;
        end
    end

    // an axis passes when twice the projected distance fits in the radii plus tolerance
    always_comb
    begin
        p_abs = '0;
        lhs   = '0;
        rhs   = '0;
        for (int j = 0; j < 4; j++)
        begin
            p_abs      = p_reg[j][PROD_W-1] ? PROD_W'(-p_reg[j]) : PROD_W'(p_reg[j]);
            lhs        = SUM_W'({p_abs, 1'b0});
            rhs        = SUM_W'(rp_reg[j]) + k2_reg[j];
            axis_ok[j] = (lhs <= rhs);
        end
        collides_next = !sgap_reg && (&axis_ok);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            collides_reg <= collides_next;
    end

    assign out_valid = out_valid_reg;
    assign collides  = collides_reg;

    `YBPO_ASSERT_NEXT(a_gap_clears_hit, en && sv_reg && sgap_reg, out_valid && !collides)
    `YBPO_ASSERT_NEXT(a_stage_advance, en && sv_reg, out_valid)
    `YBPO_ASSERT_NEXT(a_cfg_write, cfg_valid, tol_reg == $past(cfg_data))

endmodule

/* hdl/ybpo_cordic.sv */
// Pipelined CORDIC giving signed cosine and sine, and their magnitudes, of a binary angle
module ybpo_cordic
    import ybpo_pkg::*;
(
    input  logic                  clk,
    input  logic                  en,
    input  logic [ANGLE_BITS-1:0] angle,
    output trig_t                 trig
);

    logic signed [XY_BITS-1:0] x_reg [0:CORDIC_STEPS];
    logic signed [XY_BITS-1:0] y_reg [0:CORDIC_STEPS];
    logic signed [Z_BITS-1:0]  z_reg [0:CORDIC_STEPS];
    logic        [1:0]         q_reg [0:CORDIC_STEPS];

    logic signed [XY_BITS-1:0] x_next [0:CORDIC_STEPS-1];
    logic signed [XY_BITS-1:0] y_next [0:CORDIC_STEPS-1];
    logic signed [Z_BITS-1:0]  z_next [0:CORDIC_STEPS-1];

    logic [31:0]               turn;
    logic signed [XY_BITS-1:0] xc;
    logic signed [XY_BITS-1:0] yc;
    logic [MAG_BITS-1:0]       cr;
    logic [MAG_BITS-1:0]       sr;
    trig_t                     trig_next;
    trig_t                     trig_reg;

    assign turn = {angle, {(32 - ANGLE_BITS){1'b0}}};

    always_comb
    begin
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (!z_reg[i][Z_BITS-1])
            begin
                x_next[i] = x_reg[i] - (y_reg[i] >>> i);
                y_next[i] = y_reg[i] + (x_reg[i] >>> i);
                z_next[i] = z_reg[i] - $signed(ATAN_TURN[i]);
            end
            else
            begin
                x_next[i] = x_reg[i] + (y_reg[i] >>> i);
                y_next[i] = y_reg[i] - (x_reg[i] >>> i);
                z_next[i] = z_reg[i] + $signed(ATAN_TURN[i]);
            end
        end
    end

    // clamp to [0, 1] and round half up to the trig scale
    always_comb
    begin
        xc = x_reg[CORDIC_STEPS];
        yc = y_reg[CORDIC_STEPS];
        if (xc < 0)
            xc = '0;
        else if (xc > CORDIC_ONE)
            xc = CORDIC_ONE;
        if (yc < 0)
            yc = '0;
        else if (yc > CORDIC_ONE)
            yc = CORDIC_ONE;
        xc = (xc + XY_BITS'(1 << (TRIG_SHIFT - 1))) >>> TRIG_SHIFT;
        yc = (yc + XY_BITS'(1 << (TRIG_SHIFT - 1))) >>> TRIG_SHIFT;
        cr = xc[MAG_BITS-1:0];
        sr = yc[MAG_BITS-1:0];
        unique case (q_reg[CORDIC_STEPS])
            QUAD_0:
            begin
                trig_next.cos_s = $signed({1'b0, cr});
                trig_next.sin_s = $signed({1'b0, sr});
                trig_next.cos_m = cr;
                trig_next.sin_m = sr;
            end
            QUAD_1:
            begin
                trig_next.cos_s = -$signed({1'b0, sr});
                trig_next.sin_s = $signed({1'b0, cr});
                trig_next.cos_m = sr;
                trig_next.sin_m = cr;
            end
            QUAD_2:
            begin
                trig_next.cos_s = -$signed({1'b0, cr});
                trig_next.sin_s = -$signed({1'b0, sr});
                trig_next.cos_m = cr;
                trig_next.sin_m = sr;
            end
            default:
            begin
                trig_next.cos_s = $signed({1'b0, sr});
                trig_next.sin_s = -$signed({1'b0, cr});
                trig_next.cos_m = sr;
                trig_next.sin_m = cr;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= CORDIC_GAIN;
            y_reg[0] <= '0;
            z_reg[0] <= $signed({2'b00, turn[29:0]});
            q_reg[0] <= turn[31:30];
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                x_reg[i+1] <= x_next[i];
                y_reg[i+1] <= y_next[i];
                z_reg[i+1] <= z_next[i];
                q_reg[i+1] <= q_reg[i];
            end
            trig_reg <= trig_next;
        end
    end

    assign trig = trig_reg;

endmodule

/* tb/yaw_box_pair_overlap_test_checker.sv */
// Checker for the yaw box pair overlap test: predicts each collision flag and compares it
`timescale 1ns / 100ps

module yaw_box_pair_overlap_test_checker
    import ybpo_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] delta_x,
    input  logic signed [COORD_BITS-1:0] delta_y,
    input  logic signed [COORD_BITS-1:0] delta_z,
    input  logic        [SIZE_BITS-1:0]  size_a_x,
    input  logic        [SIZE_BITS-1:0]  size_a_y,
    input  logic        [SIZE_BITS-1:0]  size_a_z,
    input  logic        [ANGLE_BITS-1:0] yaw_a,
    input  logic        [SIZE_BITS-1:0]  size_b_x,
    input  logic        [SIZE_BITS-1:0]  size_b_y,
    input  logic        [SIZE_BITS-1:0]  size_b_z,
    input  logic        [ANGLE_BITS-1:0] yaw_b,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic                         collides,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic        [TOL_BITS-1:0]   cfg_data,
    output int                           fail_count,
    output int                           pending,
    output int                           hits_seen
);

    logic [TOL_BITS-1:0] tolerance;
    bit                  flag_queue[$];

    function automatic longint unsigned magnitude(longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    function automatic longint round_trig(longint v);
        if (v < 0)
            v = 0;
        if (v > longint'(CORDIC_ONE))
            v = longint'(CORDIC_ONE);
        return (v + ((longint'(1) << TRIG_SHIFT) >> 1)) >>> TRIG_SHIFT;
    endfunction

    // rotate the angle within its quadrant, then place it by quadrant
    function automatic void yaw_sincos(input logic [ANGLE_BITS-1:0] yaw,
                                       output longint c, output longint s);
        logic [31:0] turn;
        logic [1:0]  quad;
        longint      x;
        longint      y;
        longint      z;
        longint      tx;
        longint      ty;
        longint      cr;
        longint      sr;
        turn = {yaw, {(32 - ANGLE_BITS){1'b0}}};
        quad = turn[31:30];
        x = longint'(CORDIC_GAIN);
        y = 0;
        z = longint'(turn[29:0]);
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            tx = y >>> i;
            ty = x >>> i;
            if (z >= 0)
            begin
                x = x - tx;
                y = y + ty;
                z = z - longint'(ATAN_TURN[i]);
            end
            else
            begin
                x = x + tx;
                y = y - ty;
                z = z + longint'(ATAN_TURN[i]);
            end
        end
        cr = round_trig(x);
        sr = round_trig(y);
        case (quad)
            QUAD_0: begin c = cr;  s = sr;  end
            QUAD_1: begin c = -sr; s = cr;  end
            QUAD_2: begin c = -cr; s = -sr; end
            default: begin c = sr; s = -cr; end
        endcase
    endfunction

    function automatic bit axis_overlaps(longint p, longint unsigned own,
                                         longint unsigned ox, longint unsigned oz,
                                         longint unsigned cr, longint unsigned sr);
        longint unsigned lhs;
        longint unsigned rhs;
        lhs = magnitude(p) << 1;
        rhs = (own << TRIG_FRAC) + ox * cr + oz * sr
            + (longint'(tolerance) << (TRIG_FRAC + 1));
        return lhs <= rhs;
    endfunction

    function automatic bit predict_collision();
        longint          dx;
        longint          dy;
        longint          dz;
        longint unsigned ax;
        longint unsigned az;
        longint unsigned bx;
        longint unsigned bz;
        longint          ca;
        longint          sa;
        longint          cb;
        longint          sb;
        longint          cd;
        longint          sd;
        longint unsigned acd;
        longint unsigned asd;
        logic [ANGLE_BITS-1:0] rel;
        dx = delta_x;
        dy = delta_y;
        dz = delta_z;
        ax = size_a_x;
        az = size_a_z;
        bx = size_b_x;
        bz = size_b_z;
        if ((magnitude(dy) << 1) >= longint'(size_a_y) + longint'(size_b_y))
            return 1'b0;
        rel = yaw_b - yaw_a;
        yaw_sincos(yaw_a, ca, sa);
        yaw_sincos(yaw_b, cb, sb);
        yaw_sincos(rel, cd, sd);
        acd = magnitude(cd);
        asd = magnitude(sd);
        if (!axis_overlaps(dx * ca + dz * sa, ax, bx, bz, acd, asd))
            return 1'b0;
        if (!axis_overlaps(dz * ca - dx * sa, az, bx, bz, asd, acd))
            return 1'b0;
        if (!axis_overlaps(dx * cb + dz * sb, bx, ax, az, acd, asd))
            return 1'b0;
        if (!axis_overlaps(dz * cb - dx * sb, bz, ax, az, asd, acd))
            return 1'b0;
        return 1'b1;
    endfunction

    assign pending = flag_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        bit want;
        if (!rst_n)
        begin
            tolerance  <= '0;
            fail_count <= 0;
            hits_seen  <= 0;
            flag_queue.delete();
        end
        else
        begin
            // predict with the tolerance in force before this edge
            if (in_valid && !in_stall)
                flag_queue.push_back(predict_collision());
            if (cfg_valid && cfg_ready)
                tolerance <= cfg_data;
            if (out_valid && !out_stall)
            begin
                if (flag_queue.size() == 0)
                begin
                    $error("collides: no result expected, actual %0b", collides);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = flag_queue.pop_front();
                    if (collides !== want)
                    begin
                        $error("collides: expected %0b, actual %0b", want, collides);
                        fail_count <= fail_count + 1;
                    end
                    if (want)
                        hits_seen <= hits_seen + 1;
                end
            end
        end
    end

endmodule

/* tb/tb_yaw_box_pair_overlap_test.sv */
// Stimulus and verdict for the yaw box pair overlap test
`timescale 1ns / 100ps

module tb_yaw_box_pair_overlap_test;
    import ybpo_pkg::*;

    localparam int LATENCY_WAIT = 60;
    localparam int STALL_LIMIT  = 20000;
    localparam int HOLD_CYCLES  = 400;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic signed [COORD_BITS-1:0] delta_x = '0;
    logic signed [COORD_BITS-1:0] delta_y = '0;
    logic signed [COORD_BITS-1:0] delta_z = '0;
    logic        [SIZE_BITS-1:0]  size_a_x = '0;
    logic        [SIZE_BITS-1:0]  size_a_y = '0;
    logic        [SIZE_BITS-1:0]  size_a_z = '0;
    logic        [ANGLE_BITS-1:0] yaw_a = '0;
    logic        [SIZE_BITS-1:0]  size_b_x = '0;
    logic        [SIZE_BITS-1:0]  size_b_y = '0;
    logic        [SIZE_BITS-1:0]  size_b_z = '0;
    logic        [ANGLE_BITS-1:0] yaw_b = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic                         collides;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic        [TOL_BITS-1:0]   cfg_data = '0;

    int fail_count;
    int pending;
    int hits_seen;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int holds_done    = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;
    int pairs_sent    = 0;

    always #1 clk = ~clk;

    yaw_box_pair_overlap_test uut (.*);

    yaw_box_pair_overlap_test_checker u_checker (.*);

    // receiver: random stall, or a long hold when asked
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall = 1'b1;
            hold_left = hold_left - 1;
        end
        else if (hold_requests != holds_done)
        begin
            out_stall = 1'b1;
            holds_done = holds_done + 1;
            hold_left = HOLD_CYCLES - 1;
        end
        else
            out_stall = ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_pair(input logic [31:0] dx, input logic [31:0] dy,
                             input logic [31:0] dz,
                             input logic [30:0] ax, input logic [30:0] ay,
                             input logic [30:0] az, input logic [15:0] ya,
                             input logic [30:0] bx, input logic [30:0] by,
                             input logic [30:0] bz, input logic [15:0] yb);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        delta_x = dx; delta_y = dy; delta_z = dz;
        size_a_x = ax; size_a_y = ay; size_a_z = az; yaw_a = ya;
        size_b_x = bx; size_b_y = by; size_b_z = bz; yaw_b = yb;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        pairs_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        wait (pending == 0);
        repeat (LATENCY_WAIT) @(negedge clk);
    endtask

    task automatic write_tolerance(input logic [TOL_BITS-1:0] tol);
        drain();
        cfg_data  = tol;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // mostly boxes of similar scale near contact, sometimes raw full-width values
    task automatic send_random_pair();
        logic [31:0] d [3];
        logic [30:0] s [6];
        int          span;
        if ($urandom_range(9) == 0)
        begin
            foreach (d[i]) d[i] = $urandom;
            foreach (s[i]) s[i] = 31'($urandom);
        end
        else
        begin
            span = $urandom_range(28, 4);
            foreach (s[i]) s[i] = 31'($urandom_range((1 << span) - 1));
            foreach (d[i]) d[i] = $signed($urandom_range((1 << span) - 1))
                                  - (1 << (span - 1));
            if ($urandom_range(3) == 0)
                d[1] = (($urandom_range(1) == 1) ? -1 : 1) * ((s[1] + s[4]) >> 1);
        end
        send_pair(d[0], d[1], d[2], s[0], s[1], s[2], 16'($urandom),
                  s[3], s[4], s[5], 16'($urandom));
    endtask

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: extremes, exact vertical touch, quadrants, degenerate boxes
        send_pair(32'h8000_0000, 0, 32'h7FFF_FFFF, '1, '1, '1, 0, '1, '1, '1, 16'hFFFF);
        send_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_pair(0, 0, 0, 0, 2, 0, 0, 0, 2, 0, 0);
        send_pair(0, 32'd100, 0, 64, 100, 64, 0, 64, 100, 64, 0);
        send_pair(0, -32'sd100, 0, 64, 100, 64, 0, 64, 100, 64, 0);
        send_pair(0, 32'd99, 0, 64, 100, 64, 0, 64, 100, 64, 0);
        send_pair(32'd128, 0, 0, 128, 10, 128, 0, 128, 10, 128, 0);
        send_pair(32'd129, 0, 0, 128, 10, 128, 0, 128, 10, 128, 0);
        send_pair(0, 0, 32'd128, 128, 10, 128, 16384, 128, 10, 128, 32768);
        send_pair(-32'sd129, 0, 0, 128, 10, 128, 49152, 128, 10, 128, 16384);
        send_pair(32'd90, 0, 32'd90, 128, 10, 128, 8192, 128, 10, 128, 8192);
        send_pair(32'd181, 0, 0, 128, 10, 128, 8192, 128, 10, 128, 0);
        send_pair(32'h7FFF_FFFF, 0, 32'h8000_0000, '1, '1, '1, 16384, '1, '1, '1, 49152);
        send_pair(32'd1 << 24, 0, 0, 0, 4, 0, 0, 0, 4, 0, 16'hFFFF);
        write_tolerance(16'hFFFF);
        send_pair(32'h0002_0000, 0, 0, 0, 4, 0, 0, 0, 4, 0, 0);
        send_pair(32'h0002_0001, 0, 0, 0, 4, 0, 0, 0, 4, 0, 0);
        send_pair(0, 0, 32'h0003_0000, 32'h1_0000, 4, 0, 16384, 0, 4, 0, 3);

        write_tolerance(16'd1);
        send_idle_pct = 24;
        recv_idle_pct = 76;
        repeat (500) send_random_pair();

        write_tolerance(16'h8000);
        send_idle_pct = 76;
        recv_idle_pct = 24;
        repeat (500) send_random_pair();

        write_tolerance(16'd0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // hold the output while items keep coming so the pipeline backs up
        hold_requests++;
        repeat (150) send_random_pair();
        drain();
        repeat (380) send_random_pair();

        drain();
        $display("Covered %0d box pairs, %0d overlapping, over tolerances 0, 1, 32768, 65535,",
                 pairs_sent, hits_seen);
        $display("with sender and receiver idling in turn and one long output hold.");
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
